/* hdl/warning_subframe_decoder_core_assert.svh */
// Assertion macros used by the warning subframe decoder core.
`ifndef WARNING_SUBFRAME_DECODER_CORE_ASSERT_SVH
`define WARNING_SUBFRAME_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define WSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/wsd_pkg.sv */
// Types, code tables and lookup functions of the warning subframe decoder.
package wsd_pkg;

  localparam int AreaTableSize = 53;
  localparam int PayloadBits   = 16;

  typedef enum logic [1:0] {
    KIND_AREA = 2'd0,
    KIND_DATE = 2'd1,
    KIND_TIME = 2'd2
  } wsd_kind_e;

  typedef enum logic {
    CFG_CODE_A = 1'b0,
    CFG_CODE_B = 1'b1
  } wsd_cfg_e;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_ZERO = 2'd1,
    CLS_ONE  = 2'd2,
    CLS_RSVD = 2'd3
  } wsd_cls_e;

  typedef struct packed {
    wsd_kind_e   field_kind;
    logic        start_form;
    logic        sync_select;
    logic [5:0]  area_index;
    logic [11:0] zone_code;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [4:0]  hour_of_day;
    logic [3:0]  year_cycle;
    logic        even_flag;
    logic        alarm_on;
  } wsd_result_t;

  localparam logic [11:0] AREA_TAB [AreaTableSize] = '{
    12'h34D, 12'h5A5, 12'h72A, 12'h8D5, 12'h699, 12'h553,
    12'h16B, 12'h467, 12'h5D4, 12'h758, 12'hAC6, 12'hE4C,
    12'h1AE, 12'hC69, 12'hE38, 12'h98B, 12'h64B, 12'h1C7,
    12'hAAC, 12'h56C, 12'h4CE, 12'h539, 12'h6A6, 12'h92D,
    12'hD4A, 12'h9D2, 12'hA65, 12'hA5A, 12'h966, 12'h2DC,
    12'hCE4, 12'h59A, 12'hCB2, 12'h674, 12'hA93, 12'h396,
    12'hD23, 12'h31B, 12'h2B5, 12'hB31, 12'hB98, 12'hE62,
    12'h9B4, 12'h19D, 12'h2E3, 12'h62D, 12'h959, 12'hA2B,
    12'h8A7, 12'hC8D, 12'hD1C, 12'hD45, 12'h372
  };

  localparam logic [4:0] DAY_TAB [31] = '{
    5'd16, 5'd8, 5'd24, 5'd4, 5'd20, 5'd12, 5'd28, 5'd2, 5'd18, 5'd10,
    5'd26, 5'd6, 5'd22, 5'd14, 5'd30, 5'd1, 5'd17, 5'd9, 5'd25, 5'd5,
    5'd21, 5'd13, 5'd29, 5'd3, 5'd19, 5'd11, 5'd27, 5'd7, 5'd23, 5'd15,
    5'd31
  };

  localparam logic [4:0] MONTH_TAB [12] = '{
    5'd17, 5'd9, 5'd25, 5'd5, 5'd21, 5'd13, 5'd29, 5'd3, 5'd19, 5'd11,
    5'd27, 5'd7
  };

  localparam logic [4:0] HOUR_TAB [24] = '{
    5'd3, 5'd19, 5'd11, 5'd27, 5'd7, 5'd23, 5'd15, 5'd31, 5'd1, 5'd17,
    5'd9, 5'd25, 5'd5, 5'd21, 5'd13, 5'd29, 5'd2, 5'd18, 5'd10, 5'd26,
    5'd6, 5'd22, 5'd14, 5'd30
  };

  localparam logic [4:0] YEAR_TAB [10] = '{
    5'd21, 5'd13, 5'd29, 5'd3, 5'd19, 5'd11, 5'd17, 5'd9, 5'd25, 5'd5
  };

  // Day 1..31, zero for a code not in the table.
  function automatic logic [4:0] day_lookup(logic [4:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 31; i++) begin
      if (DAY_TAB[i] == v) r = 5'(i + 1);
    end
    return r;
  endfunction

  // Month 1..12, zero for a code not in the table.
  function automatic logic [3:0] month_lookup(logic [4:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < 12; i++) begin
      if (MONTH_TAB[i] == v) r = 4'(i + 1);
    end
    return r;
  endfunction

  // {hit, hour 0..23}
  function automatic logic [5:0] hour_lookup(logic [4:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 24; i++) begin
      if (HOUR_TAB[i] == v) r = {1'b1, 5'(i)};
    end
    return r;
  endfunction

  // {hit, cycle 0..9}
  function automatic logic [4:0] year_lookup(logic [4:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 10; i++) begin
      if (YEAR_TAB[i] == v) r = {1'b1, 4'(i)};
    end
    return r;
  endfunction

endpackage

/* hdl/warning_subframe_decoder_core.sv */
// Warning subframe decoder: bit scanner, payload capture and result register.
//
// Input stream: one classified bit period per request (tdata[1:0]: 0 none,
// 1 zero, 2 one, 3 read as zero). A none bit drops back to sync search.
// A 16-bit sliding window is compared with fixed_code_a / fixed_code_b; after
// a match the next 16 bits form a payload that is decoded as area, date or
// time. A valid field gives one result request; everything else gives none.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 fixed_code_a, 1 fixed_code_b); write only while idle.
// Throughput: one input bit per cycle unless the last payload bit waits (below).
// The result of the last payload bit is registered, valid the cycle after it is taken.
// The output register holds a waiting result; while it stalls, input is still
// taken except on the last payload bit, which waits until the slot frees.
// Reset clears the scanner, the alarm flag and the output valid; the sync words
// return to 0x0E6D and 0xF192.
module warning_subframe_decoder_core import wsd_pkg::*; #(
  parameter int AREA_ENTRIES = 53
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] bit_class, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] field_kind, [2] start_form, [3] sync_select, [9:4] area_index,
  // [21:10] zone_code, [26:22] day_of_month, [30:27] month_number,
  // [35:31] hour_of_day, [39:36] year_cycle, [40] even_flag, [41] alarm_on
  output logic [47:0] m_axis_tdata
);

  `include "warning_subframe_decoder_core_assert.svh"

  logic [15:0] code_a_q, code_b_q;
  logic        capturing_q, capturing_d;
  logic [15:0] window_q, window_d;
  logic [15:0] payload_q, payload_d;
  logic [4:0]  count_q, count_d;
  logic        sync_sel_q, sync_sel_d;
  logic        alarm_q, alarm_d;
  logic        out_valid_q, out_valid_d;
  wsd_result_t out_q, out_d;

  logic        accept;
  logic        last_bit;
  logic        bit_val;
  logic [15:0] win_next;
  logic [15:0] pay_next;
  wsd_cls_e    cls;
  logic        cls_valid;
  logic        cls_alarm;
  wsd_result_t cls_res;
  logic        load_out;

  assign cls      = wsd_cls_e'(s_axis_tdata[1:0]);
  assign bit_val  = (cls == CLS_ONE);
  assign win_next = {window_q[14:0], bit_val};
  assign pay_next = {payload_q[14:0], bit_val};
  // The last payload bit is the only one that can produce a result.
  assign last_bit = capturing_q && (count_q == 5'(PayloadBits - 1));

  assign s_axis_tready = !last_bit || !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  wsd_classify #(
    .AREA_ENTRIES(AREA_ENTRIES)
  ) u_classify (
    .payload_i (pay_next),
    .sync_sel_i(sync_sel_q),
    .alarm_i   (alarm_q),
    .valid_o   (cls_valid),
    .alarm_d_o (cls_alarm),
    .res_o     (cls_res)
  );

  always_comb begin
    capturing_d = capturing_q;
    window_d    = window_q;
    payload_d   = payload_q;
    count_d     = count_q;
    sync_sel_d  = sync_sel_q;
    alarm_d     = alarm_q;
    load_out    = 1'b0;
    if (accept) begin
      if (cls == CLS_NONE) begin
        capturing_d = 1'b0;
        window_d    = '0;
        count_d     = '0;
      end else if (!capturing_q) begin
        window_d = win_next;
        if (win_next == code_a_q || win_next == code_b_q) begin
          sync_sel_d  = (win_next != code_a_q);
          capturing_d = 1'b1;
          payload_d   = '0;
          count_d     = '0;
        end
      end else begin
        payload_d = pay_next;
        count_d   = count_q + 5'd1;
        if (last_bit) begin
          capturing_d = 1'b0;
          window_d    = '0;
          alarm_d     = cls_alarm;
          load_out    = cls_valid;
        end
      end
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (load_out) begin
      out_d       = cls_res;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_a_q    <= 16'h0E6D;
      code_b_q    <= 16'hF192;
      capturing_q <= 1'b0;
      window_q    <= '0;
      payload_q   <= '0;
      count_q     <= '0;
      sync_sel_q  <= 1'b0;
      alarm_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (wsd_cfg_e'(cfg_idx_i))
          CFG_CODE_A: code_a_q <= cfg_data_i;
          CFG_CODE_B: code_b_q <= cfg_data_i;
          default: ;
        endcase
      end
      capturing_q <= capturing_d;
      window_q    <= window_d;
      payload_q   <= payload_d;
      count_q     <= count_d;
      sync_sel_q  <= sync_sel_d;
      alarm_q     <= alarm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0,
                          out_q.alarm_on,
                          out_q.even_flag,
                          out_q.year_cycle,
                          out_q.hour_of_day,
                          out_q.month_number,
                          out_q.day_of_month,
                          out_q.zone_code,
                          out_q.area_index,
                          out_q.sync_select,
                          out_q.start_form,
                          out_q.field_kind};

  `WSD_ASSERT_IMP(a_count_range, capturing_q, count_q < 5'(PayloadBits), "payload count overrun")
  `WSD_ASSERT_IMP(a_no_overwrite, load_out, !out_valid_q || m_axis_tready, "result overwritten")
  `WSD_ASSERT_NXT(a_capture_ends, accept && last_bit, !capturing_q, "capture did not end")
  `WSD_ASSERT_NXT(a_alarm_match, load_out, m_axis_tvalid && (m_axis_tdata[41] == alarm_q),
                  "alarm flag and result disagree")

endmodule

/* hdl/wsd_classify.sv */
// Payload classifier: area / date / time decode of one completed payload.
module wsd_classify import wsd_pkg::*; #(
  parameter int AREA_ENTRIES = 53
) (
  input  logic [15:0]  payload_i,
  input  logic         sync_sel_i,
  input  logic         alarm_i,
  output logic         valid_o,
  output logic         alarm_d_o,
  output wsd_result_t  res_o
);

  logic [1:0]  pre2;
  logic [2:0]  pre3;
  logic [1:0]  suf;
  logic [4:0]  hi5;
  logic [4:0]  lo5;
  logic [11:0] code;
  logic        area_form;
  logic        date_form;
  logic        time_form;
  logic        area_hit;
  logic [5:0]  hit_pos;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [5:0]  hour_r;
  logic [4:0]  year_r;

  assign pre2 = payload_i[15:14];
  assign pre3 = payload_i[15:13];
  assign suf  = payload_i[1:0];
  assign hi5  = payload_i[12:8];
  assign lo5  = payload_i[6:2];
  assign code = payload_i[13:2];

  assign area_form = (pre2 == 2'b10 && suf == 2'b00) || (pre2 == 2'b01 && suf == 2'b11);
  assign date_form = (pre3 == 3'b010 && suf == 2'b00) || (pre3 == 3'b100 && suf == 2'b11);
  assign time_form = (pre3 == 3'b011 && suf == 2'b00) || (pre3 == 3'b101 && suf == 2'b11);

  // Parallel compare against the area table; first hit wins.
  always_comb begin
    area_hit = 1'b0;
    hit_pos  = '0;
    for (int i = 0; i < AreaTableSize; i++) begin
      if (i < AREA_ENTRIES && !area_hit && AREA_TAB[i] == code) begin
        area_hit = 1'b1;
        hit_pos  = 6'(i);
      end
    end
  end

  assign day    = day_lookup(hi5);
  assign month  = month_lookup(lo5);
  assign hour_r = hour_lookup(hi5);
  assign year_r = year_lookup(lo5);

  always_comb begin
    res_o             = '0;
    res_o.sync_select = sync_sel_i;
    res_o.alarm_on    = alarm_i;
    valid_o           = 1'b0;
    alarm_d_o         = alarm_i;
    if (area_form) begin
      if (area_hit) begin
        valid_o          = 1'b1;
        alarm_d_o        = (pre2 == 2'b10);
        res_o.field_kind = KIND_AREA;
        res_o.start_form = (pre2 == 2'b10);
        res_o.area_index = hit_pos;
        res_o.zone_code  = code;
        res_o.alarm_on   = (pre2 == 2'b10);
      end
    end else if (date_form) begin
      if (day != '0 && month != '0) begin
        valid_o            = 1'b1;
        res_o.field_kind   = KIND_DATE;
        res_o.start_form   = (pre3 == 3'b010);
        res_o.day_of_month = day;
        res_o.month_number = month;
        res_o.even_flag    = payload_i[7];
      end
    end else if (time_form) begin
      if (hour_r[5] && year_r[4]) begin
        valid_o           = 1'b1;
        res_o.field_kind  = KIND_TIME;
        res_o.start_form  = (pre3 == 3'b011);
        res_o.hour_of_day = hour_r[4:0];
        res_o.year_cycle  = year_r[3:0];
        res_o.even_flag   = payload_i[7];
      end
    end
  end

endmodule
